// File: rtl/s1blc_pkg.sv
// Package for the block link control engine: codes, phases, record types.
// No dependencies.
`default_nettype none
package s1blc_pkg;
	localparam int MAX_BLOCK = 256;
	localparam int TXA_W = 8;

	localparam logic [7:0] C_ENQ = 8'h05;
	localparam logic [7:0] C_EOT = 8'h04;
	localparam logic [7:0] C_ACK = 8'h06;
	localparam logic [7:0] C_NAK = 8'h15;

	localparam logic [2:0] REQ_BYTE  = 3'd0;
	localparam logic [2:0] REQ_TICK  = 3'd1;
	localparam logic [2:0] REQ_LOAD  = 3'd2;
	localparam logic [2:0] REQ_START = 3'd3;
	localparam logic [2:0] REQ_SLOT  = 3'd4;

	localparam logic [2:0] EV_NONE  = 3'd0;
	localparam logic [2:0] EV_DATA  = 3'd1;
	localparam logic [2:0] EV_GOOD  = 3'd2;
	localparam logic [2:0] EV_BAD   = 3'd3;
	localparam logic [2:0] EV_DONE  = 3'd4;
	localparam logic [2:0] EV_FAIL  = 3'd5;
	localparam logic [2:0] EV_BUSY  = 3'd6;

	localparam logic [1:0] REG_TIMEOUT = 2'd0;
	localparam logic [1:0] REG_RETRY   = 2'd1;
	localparam logic [1:0] REG_SLAVE   = 2'd2;
	localparam logic [1:0] REG_MAXLEN  = 2'd3;

	typedef enum logic [3:0] {
		P_IDLE, P_RX_LEN_LO, P_RX_LEN_HI, P_RX_DATA, P_RX_SUM,
		P_ARB_WAIT, P_TX_SEND, P_TX_WAIT_ACK
	} phase_t;

	typedef struct packed {
		logic       line_valid;
		logic [7:0] line_byte;
		logic [2:0] host_event;
		logic [7:0] host_byte;
		logic [8:0] host_length;
	} res_t;

	// word queued between front and back: up to two results
	typedef struct packed {
		logic  two;
		logic  rd;       // first-slot line byte comes from tx store read
		res_t  r0;
		res_t  r1;
	} job_t;
endpackage
`default_nettype wire

// File: rtl/s1blc_engine.sv
// Front part: protocol state, classifies each input word into its results.
// Depends on s1blc_pkg. Holds the transmit store (read data registered).
`default_nettype none
module s1blc_engine
	import s1blc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_data,
	input  wire logic        in_go,
	input  wire logic [2:0]  req,
	input  wire logic [7:0]  bval,
	output logic             job_valid,
	output job_t             job,
	output logic [7:0]       rd_data
);
	logic [15:0] timeout_q;
	logic [3:0]  limit_q;
	logic        slave_q;
	logic [8:0]  maxlen_q;
	phase_t      phase_q, phase_d;
	logic [15:0] timer_q, timer_d;
	logic [3:0]  retry_q, retry_d;
	logic        supp_q, supp_d, pend_q, pend_d;
	logic [8:0]  txc_q, txc_d, txp_q, txp_d;
	logic [31:0] txs_q, txs_d;
	logic [15:0] rxl_q, rxl_d;
	logic [8:0]  rxp_q, rxp_d;
	logic [31:0] rxs_q, rxs_d, rxe_q, rxe_d;
	logic [7:0]  mem [MAX_BLOCK];
	logic        we;
	logic [TXA_W-1:0] ra;
	res_t        rs [2];
	logic [1:0]  n;
	logic        rdf;
	logic [3:0]  lim, rinc;
	logic        tmo;
	logic [15:0] lenf;
	logic [8:0]  pp;
	logic [9:0]  sidx;

	always_ff @(posedge clk) begin
		if (we) mem[txc_q[TXA_W-1:0]] <= bval;
		rd_data <= mem[ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= 16'd4096; limit_q <= 4'd3; slave_q <= 1'b0; maxlen_q <= 9'd256;
			phase_q <= P_IDLE; timer_q <= '0; retry_q <= '0; supp_q <= 1'b0;
			pend_q <= 1'b0; txc_q <= '0; txp_q <= '0; txs_q <= '0; rxl_q <= '0;
			rxp_q <= '0; rxs_q <= '0; rxe_q <= '0; job_valid <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_TIMEOUT: timeout_q <= cfg_data;
					REG_RETRY:   limit_q <= cfg_data[3:0];
					REG_SLAVE:   slave_q <= cfg_data[0];
					REG_MAXLEN:  maxlen_q <= cfg_data[8:0];
					default: ;
				endcase
			end
			job_valid <= in_go && (n != 2'd0);
			if (in_go) begin
				phase_q <= phase_d; timer_q <= timer_d; retry_q <= retry_d;
				supp_q <= supp_d; pend_q <= pend_d; txc_q <= txc_d; txp_q <= txp_d;
				txs_q <= txs_d; rxl_q <= rxl_d; rxp_q <= rxp_d; rxs_q <= rxs_d;
				rxe_q <= rxe_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_go) begin
			job.two <= (n == 2'd2);
			job.rd <= rdf;
			job.r0 <= rs[0];
			job.r1 <= rs[1];
		end
	end

	always_comb begin
		phase_d = phase_q; timer_d = timer_q; retry_d = retry_q; supp_d = supp_q;
		pend_d = pend_q; txc_d = txc_q; txp_d = txp_q; txs_d = txs_q; rxl_d = rxl_q;
		rxp_d = rxp_q; rxs_d = rxs_q; rxe_d = rxe_q;
		rs[0] = '0; rs[1] = '0; n = 2'd0; rdf = 1'b0; we = 1'b0;
		ra = txp_q[TXA_W-1:0] - TXA_W'(2);
		lim = (limit_q == 4'd0) ? 4'd1 : limit_q;
		rinc = retry_q + 4'd1;
		tmo = (timer_q <= 16'd1);
		lenf = {bval, rxl_q[7:0]};
		pp = txp_q - txc_q - 9'd2;
		sidx = {1'b0, txc_q} + 10'd2;
		case (req)
			REQ_BYTE: begin
				case (phase_q)
					P_IDLE: if (bval == C_ENQ) begin
						rs[0] = '{1'b1, C_EOT, EV_NONE, 8'd0, 9'd0}; n = 2'd1;
						phase_d = P_RX_LEN_LO; rxl_d = '0; rxp_d = '0; rxs_d = '0;
						rxe_d = '0; timer_d = timeout_q;
					end
					P_RX_LEN_LO: begin
						rxl_d = {8'd0, bval}; phase_d = P_RX_LEN_HI; timer_d = timeout_q;
					end
					P_RX_LEN_HI: begin
						rxl_d = lenf; timer_d = timeout_q; rxp_d = '0;
						if (lenf >= {7'd0, maxlen_q} || lenf > 16'(MAX_BLOCK)) begin
							rs[0] = '{1'b1, C_NAK, EV_BAD, 8'd0, 9'd0}; n = 2'd1;
							phase_d = P_IDLE;
							if (pend_q) begin
								rs[1] = '{1'b1, C_ENQ, EV_NONE, 8'd0, 9'd0}; n = 2'd2;
								phase_d = P_ARB_WAIT; supp_d = 1'b0;
							end
						end else phase_d = (lenf == 16'd0) ? P_RX_SUM : P_RX_DATA;
					end
					P_RX_DATA: begin
						timer_d = timeout_q;
						rs[0] = '{1'b0, 8'd0, EV_DATA, bval, rxp_q}; n = 2'd1;
						rxs_d = rxs_q + {24'd0, bval};
						rxp_d = rxp_q + 9'd1;
						if ({7'd0, rxp_d} >= rxl_q) begin
							rxp_d = '0; phase_d = P_RX_SUM;
						end
					end
					P_RX_SUM: begin
						timer_d = timeout_q;
						case (rxp_q[1:0])
							2'd0: rxe_d[7:0] = bval;
							2'd1: rxe_d[15:8] = bval;
							2'd2: rxe_d[23:16] = bval;
							default: rxe_d[31:24] = bval;
						endcase
						rxp_d = rxp_q + 9'd1;
						if (rxp_d >= 9'd4) begin
							if (rxe_d == rxs_q)
								rs[0] = '{1'b1, C_ACK, EV_GOOD, 8'd0, rxl_q[8:0]};
							else rs[0] = '{1'b1, C_NAK, EV_BAD, 8'd0, 9'd0};
							n = 2'd1; phase_d = P_IDLE;
							if (pend_q) begin
								rs[1] = '{1'b1, C_ENQ, EV_NONE, 8'd0, 9'd0}; n = 2'd2;
								phase_d = P_ARB_WAIT; supp_d = 1'b0;
							end
						end
					end
					P_ARB_WAIT: begin
						if (bval == C_EOT) begin
							phase_d = P_TX_SEND; txp_d = '0;
						end else if (bval == C_ENQ && slave_q) begin
							rs[0] = '{1'b1, C_EOT, EV_NONE, 8'd0, 9'd0}; n = 2'd1;
							phase_d = P_RX_LEN_LO; rxl_d = '0; rxp_d = '0; rxs_d = '0;
							rxe_d = '0; timer_d = timeout_q;
						end else begin
							retry_d = rinc;
							if (rinc >= lim || rinc == 4'd0) begin
								rs[0] = '{1'b0, 8'd0, EV_FAIL, 8'd0, 9'd0}; n = 2'd1;
								txc_d = '0; txs_d = '0; txp_d = '0; pend_d = 1'b0;
								phase_d = P_IDLE;
							end else begin
								supp_d = 1'b1; timer_d = timeout_q;
							end
						end
					end
					P_TX_WAIT_ACK: begin
						if (bval == C_ACK) begin
							rs[0] = '{1'b0, 8'd0, EV_DONE, 8'd0, 9'd0}; n = 2'd1;
							txc_d = '0; txs_d = '0; txp_d = '0; pend_d = 1'b0;
							phase_d = P_IDLE;
						end else begin
							retry_d = rinc;
							if (rinc >= lim || rinc == 4'd0) begin
								rs[0] = '{1'b0, 8'd0, EV_FAIL, 8'd0, 9'd0}; n = 2'd1;
								txc_d = '0; txs_d = '0; txp_d = '0; pend_d = 1'b0;
								phase_d = P_IDLE;
							end else begin
								rs[0] = '{1'b1, C_ENQ, EV_NONE, 8'd0, 9'd0}; n = 2'd1;
								phase_d = P_ARB_WAIT; supp_d = 1'b0; timer_d = timeout_q;
							end
						end
					end
					default: ;
				endcase
			end
			REQ_TICK: begin
				if (phase_q == P_RX_LEN_LO || phase_q == P_RX_LEN_HI ||
				    phase_q == P_RX_DATA || phase_q == P_RX_SUM ||
				    phase_q == P_ARB_WAIT || phase_q == P_TX_WAIT_ACK) begin
					timer_d = tmo ? 16'd0 : timer_q - 16'd1;
					if (tmo) begin
						if (phase_q == P_ARB_WAIT || phase_q == P_TX_WAIT_ACK) begin
							retry_d = rinc;
							if (rinc >= lim || rinc == 4'd0) begin
								rs[0] = '{1'b0, 8'd0, EV_FAIL, 8'd0, 9'd0}; n = 2'd1;
								txc_d = '0; txs_d = '0; txp_d = '0; pend_d = 1'b0;
								phase_d = P_IDLE;
							end else begin
								timer_d = timeout_q;
								if (phase_q == P_TX_WAIT_ACK) begin
									phase_d = P_ARB_WAIT; supp_d = 1'b0;
								end
								if (phase_q == P_TX_WAIT_ACK || !supp_q) begin
									rs[0] = '{1'b1, C_ENQ, EV_NONE, 8'd0, 9'd0}; n = 2'd1;
								end
							end
						end else begin
							rs[0] = '{1'b1, C_NAK, EV_BAD, 8'd0, 9'd0}; n = 2'd1;
							phase_d = P_IDLE;
							if (pend_q) begin
								rs[1] = '{1'b1, C_ENQ, EV_NONE, 8'd0, 9'd0}; n = 2'd2;
								phase_d = P_ARB_WAIT; supp_d = 1'b0; timer_d = timeout_q;
							end
						end
					end
				end
			end
			REQ_LOAD: begin
				if (pend_q || txc_q >= 9'(MAX_BLOCK)) begin
					rs[0] = '{1'b0, 8'd0, EV_BUSY, 8'd0, 9'd0}; n = 2'd1;
				end else begin
					we = 1'b1; txc_d = txc_q + 9'd1; txs_d = txs_q + {24'd0, bval};
				end
			end
			REQ_START: begin
				if (pend_q) begin
					rs[0] = '{1'b0, 8'd0, EV_BUSY, 8'd0, 9'd0}; n = 2'd1;
				end else begin
					pend_d = 1'b1; retry_d = '0; txp_d = '0;
					if (phase_q == P_IDLE) begin
						rs[0] = '{1'b1, C_ENQ, EV_NONE, 8'd0, 9'd0}; n = 2'd1;
						phase_d = P_ARB_WAIT; supp_d = 1'b0; timer_d = timeout_q;
					end
				end
			end
			REQ_SLOT: begin
				if (phase_q == P_TX_SEND) begin
					n = 2'd1;
					rs[0].line_valid = 1'b1;
					if (txp_q == 9'd0) rs[0].line_byte = txc_q[7:0];
					else if (txp_q == 9'd1) rs[0].line_byte = {7'd0, txc_q[8]};
					else if ({1'b0, txp_q} < sidx) rdf = 1'b1;
					else begin
						case (pp[1:0])
							2'd0: rs[0].line_byte = txs_q[7:0];
							2'd1: rs[0].line_byte = txs_q[15:8];
							2'd2: rs[0].line_byte = txs_q[23:16];
							default: rs[0].line_byte = txs_q[31:24];
						endcase
					end
					txp_d = txp_q + 9'd1;
					if ({1'b0, txp_d} >= {1'b0, txc_q} + 10'd6) begin
						phase_d = P_TX_WAIT_ACK; timer_d = timeout_q;
					end
				end
			end
			default: ;
		endcase
	end
endmodule
`default_nettype wire

// File: rtl/s1blc_outq.sv
// Back part: queue of classified words, expands each into one or two results.
// Depends on s1blc_pkg.
`default_nettype none
module s1blc_outq
	import s1blc_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       job_valid,
	input  wire job_t       job,
	input  wire logic [7:0] rd_data,
	output logic            room,
	output logic            o_valid,
	input  wire logic       o_ready,
	output res_t            o_res,
	output logic            o_last
);
	localparam int DEPTH = 4;
	job_t       q [DEPTH];
	logic [1:0] wp_q, rp_q;
	logic [2:0] cnt_q;
	logic       sub_q;
	logic       pop;
	job_t       jw, head;

	always_comb begin
		jw = job;
		if (job.rd) jw.r0.line_byte = rd_data;
		head = q[rp_q];
	end

	assign o_valid = (cnt_q != 3'd0);
	assign o_res = sub_q ? head.r1 : head.r0;
	assign o_last = sub_q || !head.two;
	assign pop = o_valid && o_ready && o_last;
	// two free entries cover the word in flight
	assign room = (cnt_q <= 3'(DEPTH - 2));

	always_ff @(posedge clk) begin
		if (job_valid) q[wp_q] <= jw;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0; rp_q <= '0; cnt_q <= '0; sub_q <= 1'b0;
		end else begin
			if (job_valid) wp_q <= wp_q + 2'd1;
			if (pop) rp_q <= rp_q + 2'd1;
			cnt_q <= cnt_q + {2'd0, job_valid} - {2'd0, pop};
			if (o_valid && o_ready) sub_q <= !o_last;
		end
	end
endmodule
`default_nettype wire

// File: rtl/secs1_block_link_control_unit.sv
// Top level of the block link control engine.
// Depends on s1blc_pkg, s1blc_engine, s1blc_outq.
//
// Input stream s_axis: one word per request (line byte, tick, load, start,
// transmitter slot). Output stream m_axis: zero, one or two result words per
// request, tlast on the final one of each request.
// A request is registered as a job, then queued; the queue head drives m_axis.
// Throughput: one request per cycle while s_axis_tready is high; the front
// engine updates its state per request. A four-entry queue separates it
// from the output; s_axis_tready drops when fewer than two entries are free.
// Receiver stall: m_axis words hold; the queue fills, then input stalls.
// Reset: phase idle, counters and sums clear, registers take their
// defaults (timeout 4096, retry limit 3, master mode, max length 256).
// Configuration writes are taken at any cycle with cfg_we high.
`default_nettype none
module secs1_block_link_control_unit
	import s1blc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_data,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,  // byte_value
	input  wire logic [2:0]  s_axis_tuser,  // req_type
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [31:0]      m_axis_tdata,  // line_valid, line_byte, host_event,
	                                        // host_byte, host_length, zero fill
	output logic             m_axis_tlast
);
	logic       go, jv;
	job_t       jb;
	logic [7:0] rdd;
	res_t       r;

	assign go = s_axis_tvalid && s_axis_tready;

	s1blc_engine u_eng (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_go(go), .req(s_axis_tuser), .bval(s_axis_tdata),
		.job_valid(jv), .job(jb), .rd_data(rdd)
	);

	s1blc_outq u_q (
		.clk(clk), .arst_n(arst_n), .job_valid(jv), .job(jb), .rd_data(rdd),
		.room(s_axis_tready), .o_valid(m_axis_tvalid), .o_ready(m_axis_tready),
		.o_res(r), .o_last(m_axis_tlast)
	);

	assign m_axis_tdata = {3'd0, r.host_length, r.host_byte, r.host_event,
		r.line_byte, r.line_valid};
endmodule
`default_nettype wire

// File: tb/secs1_block_link_control_checker.sv
// Checker for the block link control engine: watches the request and result
// streams, predicts result words and compares them. Depends on s1blc_pkg.
`timescale 1ns / 100ps
`default_nettype none
module secs1_block_link_control_checker
	import s1blc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_data,
	input  wire logic        s_axis_tvalid,
	input  wire logic        s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,
	input  wire logic [2:0]  s_axis_tuser,
	input  wire logic        m_axis_tvalid,
	input  wire logic        m_axis_tready,
	input  wire logic [31:0] m_axis_tdata,
	input  wire logic        m_axis_tlast,
	output int               fail_count,
	output int               pending_words,
	output int               words_seen,
	output int               good_blocks,
	output int               sends_done
);
	typedef struct packed {
		res_t r;
		logic lst;
	} word_t;

	word_t expected_words[$];

	logic [15:0] rx_timeout;
	logic [3:0]  retry_lim;
	logic        slave;
	logic [8:0]  max_len;
	phase_t      ph;
	logic [15:0] wtimer;
	logic [3:0]  retries;
	logic        enq_sup, pend;
	logic [7:0]  tx_mem [MAX_BLOCK];
	logic [8:0]  tx_cnt;
	logic [31:0] tx_ptr, tx_total;
	logic [15:0] rx_len;
	logic [31:0] rx_pos, rx_total, rx_want;
	word_t       step_out[$];

	function automatic logic [31:0] to_bus(res_t r);
		return {3'd0, r.host_length, r.host_byte, r.host_event, r.line_byte,
			r.line_valid};
	endfunction

	function automatic void push_word(logic lv, logic [7:0] lb, logic [2:0] ev,
			logic [7:0] hb, logic [8:0] hl);
		word_t w;
		if (step_out.size() >= 2) return;
		w.r = '{line_valid: lv, line_byte: lb, host_event: ev, host_byte: hb,
			host_length: hl};
		w.lst = 1'b0;
		step_out.push_back(w);
	endfunction

	function automatic void reload();
		wtimer = rx_timeout;
	endfunction

	function automatic logic timer_out();
		if (wtimer > 1) begin
			wtimer--;
			return 1'b0;
		end
		wtimer = 0;
		return 1'b1;
	endfunction

	function automatic void drop_block();
		tx_cnt = 0;
		tx_total = 0;
		tx_ptr = 0;
		pend = 0;
	endfunction

	function automatic void start_arb();
		push_word(1, C_ENQ, EV_NONE, 0, 0);
		ph = P_ARB_WAIT;
		enq_sup = 0;
		reload();
	endfunction

	function automatic void start_rx();
		push_word(1, C_EOT, EV_NONE, 0, 0);
		ph = P_RX_LEN_LO;
		rx_len = 0;
		rx_pos = 0;
		rx_total = 0;
		rx_want = 0;
		reload();
	endfunction

	function automatic void close_rx(logic good);
		if (good)
			push_word(1, C_ACK, EV_GOOD, 0, rx_len[8:0]);
		else
			push_word(1, C_NAK, EV_BAD, 0, 0);
		if (pend)
			start_arb();
		else
			ph = P_IDLE;
	endfunction

	function automatic logic attempt_failed();
		logic [3:0] lim;
		lim = (retry_lim == 0) ? 4'd1 : retry_lim;
		retries = retries + 4'd1;
		if (retries >= lim || retries == 0) begin
			push_word(0, 0, EV_FAIL, 0, 0);
			drop_block();
			ph = P_IDLE;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic void take_line_byte(logic [7:0] b);
		case (ph)
			P_IDLE: if (b == C_ENQ) start_rx();
			P_RX_LEN_LO: begin
				rx_len = {8'd0, b};
				ph = P_RX_LEN_HI;
				reload();
			end
			P_RX_LEN_HI: begin
				rx_len[15:8] = b;
				reload();
				rx_pos = 0;
				if (rx_len >= max_len || rx_len > MAX_BLOCK)
					close_rx(0);
				else
					ph = (rx_len == 0) ? P_RX_SUM : P_RX_DATA;
			end
			P_RX_DATA: begin
				reload();
				push_word(0, 0, EV_DATA, b, rx_pos[8:0]);
				rx_total += b;
				rx_pos++;
				if (rx_pos >= rx_len) begin
					rx_pos = 0;
					ph = P_RX_SUM;
				end
			end
			P_RX_SUM: begin
				reload();
				rx_want |= 32'(b) << (8 * rx_pos[1:0]);
				rx_pos++;
				if (rx_pos >= 4) close_rx(rx_want == rx_total);
			end
			P_ARB_WAIT: begin
				if (b == C_EOT) begin
					ph = P_TX_SEND;
					tx_ptr = 0;
				end else if (b == C_ENQ && slave) begin
					start_rx();
				end else if (!attempt_failed()) begin
					enq_sup = 1;
					reload();
				end
			end
			P_TX_WAIT_ACK: begin
				if (b == C_ACK) begin
					push_word(0, 0, EV_DONE, 0, 0);
					drop_block();
					ph = P_IDLE;
				end else if (!attempt_failed()) begin
					start_arb();
				end
			end
			default: ;
		endcase
	endfunction

	function automatic void take_tick();
		if (ph inside {P_RX_LEN_LO, P_RX_LEN_HI, P_RX_DATA, P_RX_SUM}) begin
			if (timer_out()) close_rx(0);
		end else if (ph == P_ARB_WAIT) begin
			if (timer_out() && !attempt_failed()) begin
				if (!enq_sup) push_word(1, C_ENQ, EV_NONE, 0, 0);
				reload();
			end
		end else if (ph == P_TX_WAIT_ACK) begin
			if (timer_out() && !attempt_failed()) start_arb();
		end
	endfunction

	function automatic void take_slot();
		logic [7:0] b;
		logic [31:0] p;
		if (ph != P_TX_SEND) return;
		p = tx_ptr;
		if (p == 0)
			b = tx_cnt[7:0];
		else if (p == 1)
			b = {7'd0, tx_cnt[8]};
		else if (p < tx_cnt + 2)
			b = tx_mem[p - 2];
		else
			b = tx_total >> (8 * ((p - tx_cnt - 2) & 3));
		push_word(1, b, EV_NONE, 0, 0);
		tx_ptr = p + 1;
		if (tx_ptr >= tx_cnt + 6) begin
			ph = P_TX_WAIT_ACK;
			reload();
		end
	endfunction

	function automatic void predict_request(logic [2:0] req, logic [7:0] b);
		step_out = {};
		case (req)
			REQ_BYTE:  take_line_byte(b);
			REQ_TICK:  take_tick();
			REQ_LOAD: begin
				if (pend || tx_cnt >= MAX_BLOCK) begin
					push_word(0, 0, EV_BUSY, 0, 0);
				end else begin
					tx_mem[tx_cnt[7:0]] = b;
					tx_cnt++;
					tx_total += b;
				end
			end
			REQ_START: begin
				if (pend) begin
					push_word(0, 0, EV_BUSY, 0, 0);
				end else begin
					pend = 1;
					retries = 0;
					tx_ptr = 0;
					if (ph == P_IDLE) start_arb();
				end
			end
			REQ_SLOT:  take_slot();
			default: ;
		endcase
		if (step_out.size() > 0) step_out[step_out.size() - 1].lst = 1'b1;
		foreach (step_out[i]) expected_words.push_back(step_out[i]);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		word_t w;
		if (!arst_n) begin
			rx_timeout = 16'd4096;
			retry_lim = 4'd3;
			slave = 0;
			max_len = 9'd256;
			ph = P_IDLE;
			wtimer = 0;
			retries = 0;
			enq_sup = 0;
			pend = 0;
			tx_cnt = 0;
			tx_ptr = 0;
			tx_total = 0;
			rx_len = 0;
			rx_pos = 0;
			rx_total = 0;
			rx_want = 0;
			expected_words = {};
			fail_count = 0;
			words_seen = 0;
			good_blocks = 0;
			sends_done = 0;
			pending_words = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				words_seen++;
				if (m_axis_tdata[11:9] == EV_GOOD) good_blocks++;
				if (m_axis_tdata[11:9] == EV_DONE) sends_done++;
				if (expected_words.size() == 0) begin
					fail_count++;
					$display("%0t: unexpected word %h last %b", $time, m_axis_tdata,
						m_axis_tlast);
				end else begin
					w = expected_words.pop_front();
					if (m_axis_tdata !== to_bus(w.r) || m_axis_tlast !== w.lst) begin
						fail_count++;
						$display("%0t: expected %h last %b, got %h last %b", $time,
							to_bus(w.r), w.lst, m_axis_tdata, m_axis_tlast);
					end
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_TIMEOUT: rx_timeout = cfg_data;
					REG_RETRY:   retry_lim = cfg_data[3:0];
					REG_SLAVE:   slave = cfg_data[0];
					REG_MAXLEN:  max_len = cfg_data[8:0];
					default: ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready)
				predict_request(s_axis_tuser, s_axis_tdata);
			pending_words = expected_words.size();
		end
	end
endmodule
`default_nettype wire

// File: tb/tb_secs1_block_link_control_unit.sv
// Testbench top for the block link control engine: clock, reset, register
// writes and request stimulus. Depends on s1blc_pkg and the checker.
`timescale 1ns / 100ps
`default_nettype none
module tb_secs1_block_link_control_unit
	import s1blc_pkg::*;
;
	logic        clk = 0;
	logic        arst_n = 0;
	logic        cfg_we = 0;
	logic [1:0]  cfg_index = REG_TIMEOUT;
	logic [15:0] cfg_data = 0;
	logic        s_axis_tvalid = 0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = 0;  // byte_value
	logic [2:0]  s_axis_tuser = REQ_TICK;  // req_type
	logic        m_axis_tvalid;
	logic        m_axis_tready = 0;
	logic [31:0] m_axis_tdata;  // line_valid, line_byte, host_event, host_byte,
	                            // host_length, zero fill
	logic        m_axis_tlast;
	int          fail_count, pending_words, words_seen, good_blocks, sends_done;
	int          requests_sent = 0;
	bit          quiet = 0;

	secs1_block_link_control_unit dut (.*);
	secs1_block_link_control_checker chk (.*);

	always begin
		#2 clk = 1;
		#2 clk = 0;
	end

	initial begin
		#4000000;
		$display("tb: failure");
		$finish;
	end

	always @(negedge clk)
		m_axis_tready <= quiet || ($urandom_range(99) >= 8);

	task automatic send_word(logic [2:0] req, logic [7:0] b);
		while (!quiet && $urandom_range(99) < 8) begin
			s_axis_tvalid <= 0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tuser <= req;
		s_axis_tdata <= b;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		requests_sent++;
		@(negedge clk);
	endtask

	task automatic drain();
		int i;
		s_axis_tvalid <= 0;
		while (pending_words != 0) @(negedge clk);
		for (i = 0; i < 8; i++) @(negedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [15:0] val);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 0;
		@(negedge clk);
	endtask

	// incoming frame: ENQ, length, data, checksum; corrupt flips the checksum
	task automatic peer_block(int len, bit corrupt, int stop_at);
		logic [31:0] sum;
		logic [7:0] d;
		int k;
		sum = 0;
		send_word(REQ_BYTE, C_ENQ);
		send_word(REQ_BYTE, len[7:0]);
		send_word(REQ_BYTE, len[15:8]);
		for (k = 0; k < len && k < 300; k++) begin
			if (k == stop_at) return;
			d = $urandom;
			sum += d;
			send_word(REQ_BYTE, d);
		end
		if (corrupt) sum ^= 32'h1 << $urandom_range(31);
		for (k = 0; k < 4; k++) send_word(REQ_BYTE, sum[8 * k +: 8]);
	endtask

	// outgoing frame: load, start, EOT, slots, then ACK or a fault
	task automatic host_send(int len, int fault);
		int k;
		for (k = 0; k < len; k++) send_word(REQ_LOAD, $urandom);
		send_word(REQ_START, $urandom);
		if (fault == 1) begin
			for (k = 0; k < 20; k++) send_word(REQ_TICK, 0);
			return;
		end
		if (fault == 2) send_word(REQ_BYTE, C_ACK);
		send_word(REQ_BYTE, C_EOT);
		for (k = 0; k < len + 6; k++) begin
			if ($urandom_range(30) == 0) send_word(REQ_BYTE, $urandom);
			send_word(REQ_SLOT, 0);
		end
		send_word(REQ_BYTE, (fault == 3) ? C_NAK : C_ACK);
	endtask

	task automatic random_phase(int n);
		int sel;
		while (n > 0) begin
			sel = $urandom_range(99);
			if (sel < 35) begin
				peer_block($urandom_range(12), $urandom_range(4) == 0,
					($urandom_range(6) == 0) ? $urandom_range(5) : 999);
				n -= 10;
			end else if (sel < 65) begin
				host_send($urandom_range(10), ($urandom_range(3) == 0) ?
					$urandom_range(1, 3) : 0);
				n -= 14;
			end else if (sel < 72) begin
				send_word(REQ_BYTE, C_ENQ);
				send_word(REQ_START, 0);
				n -= 2;
			end else begin
				send_word($urandom_range(7), $urandom);
				n--;
			end
		end
	endtask

	initial begin
		int k;
		repeat (2) @(negedge clk);
		arst_n <= 1;
		@(negedge clk);

		// directed: good, bad and oversize blocks, zero length, idle ticks, a send
		peer_block(3, 0, 999);
		peer_block(0, 0, 999);
		peer_block(2, 1, 999);
		peer_block(16'hFFFF, 0, 0);
		peer_block(256, 0, 0);
		for (k = 0; k < 3; k++) send_word(REQ_TICK, 0);
		send_word(REQ_LOAD, 8'hFF);
		send_word(REQ_LOAD, 8'h00);
		send_word(REQ_START, 0);
		send_word(REQ_START, 0);
		send_word(REQ_LOAD, 8'h5A);
		send_word(REQ_BYTE, C_ENQ);
		send_word(REQ_BYTE, C_EOT);
		for (k = 0; k < 8; k++) send_word(REQ_SLOT, 0);
		send_word(REQ_BYTE, C_ACK);
		send_word(3'd7, 8'hAA);
		send_word(3'd5, 8'h55);
		drain();

		write_reg(REG_TIMEOUT, 16'd3);
		write_reg(REG_RETRY, 4'd1);
		write_reg(REG_SLAVE, 16'd1);
		write_reg(REG_MAXLEN, 16'd1);
		quiet = 1;
		host_send(2, 1);
		send_word(REQ_START, 0);
		send_word(REQ_BYTE, C_ENQ);
		peer_block(0, 0, 999);
		peer_block(1, 0, 999);
		for (k = 0; k < 256; k++) send_word(REQ_LOAD, k);
		send_word(REQ_LOAD, 8'h11);
		drain();
		quiet = 0;
		send_word(REQ_START, 0);
		send_word(REQ_BYTE, C_EOT);
		for (k = 0; k < 262; k++) send_word(REQ_SLOT, 0);
		send_word(REQ_BYTE, C_ACK);
		drain();

		write_reg(REG_TIMEOUT, 16'd2);
		write_reg(REG_RETRY, 4'd15);
		write_reg(REG_SLAVE, 16'd0);
		write_reg(REG_MAXLEN, 16'd256);
		random_phase(200);
		drain();
		write_reg(REG_TIMEOUT, 16'd0);
		write_reg(REG_RETRY, 4'd0);
		write_reg(REG_MAXLEN, 16'd511);
		write_reg(REG_SLAVE, 16'd1);
		random_phase(150);
		drain();
		write_reg(REG_TIMEOUT, 16'hFFFF);
		write_reg(REG_RETRY, 4'd2);
		write_reg(REG_MAXLEN, 16'd8);
		random_phase(150);
		drain();
		write_reg(REG_TIMEOUT, 16'd1);
		write_reg(REG_RETRY, 4'd4);
		write_reg(REG_MAXLEN, 16'd200);
		random_phase(200);
		drain();

		$display("covered %0d requests, %0d result words, %0d good blocks, %0d sends",
			requests_sent, words_seen, good_blocks, sends_done);
		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule
`default_nettype wire
